// File: src/rgba_to_yuv420_converter_unit_assert.svh
// assertion macros shared by the rgb to yuv 4:2:0 converter modules
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef RGBA_TO_YUV420_CONVERTER_UNIT_ASSERT_SVH
`define RGBA_TO_YUV420_CONVERTER_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define R2Y_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define R2Y_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/r2y420_pkg.sv
// shared types, constants and color conversion functions of the converter
// no dependencies
`timescale 1ns / 1ps

package r2y420_pkg;

  localparam int unsigned DIM_W        = 14;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DATA_W   = 14;
  localparam int unsigned LUMA_OFF_W   = 25;
  localparam int unsigned CHROMA_OFF_W = 26;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_WIDTH     = 3'd0,
    REG_SRC_HEIGHT    = 3'd1,
    REG_LINE_STRIDE   = 3'd2,
    REG_SLICE_HEIGHT  = 3'd3,
    REG_CHROMA_PLANAR = 3'd4
  } reg_idx_e;

  localparam logic [12:0] RST_SRC_WIDTH    = 13'd640;
  localparam logic [12:0] RST_SRC_HEIGHT   = 13'd480;
  localparam logic [13:0] RST_LINE_STRIDE  = 14'd640;
  localparam logic [12:0] RST_SLICE_HEIGHT = 13'd480;

  // bt.601 coefficients
  localparam logic [15:0] Y_R         = 16'd66;
  localparam logic [15:0] Y_G         = 16'd129;
  localparam logic [15:0] Y_B         = 16'd25;
  localparam logic [15:0] CB_R        = 16'd38;
  localparam logic [15:0] CB_G        = 16'd74;
  localparam logic [15:0] CB_B        = 16'd112;
  localparam logic [15:0] CR_R        = 16'd112;
  localparam logic [15:0] CR_G        = 16'd94;
  localparam logic [15:0] CR_B        = 16'd18;
  localparam logic [15:0] ROUND       = 16'd128;
  localparam logic [15:0] CHROMA_BIAS = 16'd32896;
  localparam logic [7:0]  LUMA_OFS    = 8'd16;

  typedef struct packed {
    logic [12:0]             src_width;
    logic [12:0]             src_height;
    logic [13:0]             line_stride;
    logic [12:0]             slice_height;
    logic                    chroma_planar;
    logic [CHROMA_OFF_W-1:0] base_u;
    logic [CHROMA_OFF_W-1:0] base_v;
  } cfg_t;

  typedef struct packed {
    logic [7:0] b;
    logic [7:0] g;
    logic [7:0] r;
  } rgb8_t;

  typedef struct packed {
    logic [8:0] b;
    logic [8:0] g;
    logic [8:0] r;
  } rgb9_t;

  typedef struct packed {
    logic chroma;
    logic frame_end;
  } flags_t;

  function automatic logic [7:0] luma_of(input rgb8_t px);
    logic [15:0] s;
    s = Y_R * 16'(px.r) + Y_G * 16'(px.g) + Y_B * 16'(px.b) + ROUND;
    return s[15:8] + LUMA_OFS;
  endfunction

  // bias keeps the sum positive so the shift floors
  function automatic logic [7:0] cb_of(input rgb8_t px);
    logic [15:0] s;
    s = CB_B * 16'(px.b) + CHROMA_BIAS - CB_R * 16'(px.r) - CB_G * 16'(px.g);
    return s[15:8];
  endfunction

  function automatic logic [7:0] cr_of(input rgb8_t px);
    logic [15:0] s;
    s = CR_R * 16'(px.r) + CHROMA_BIAS - CR_G * 16'(px.g) - CR_B * 16'(px.b);
    return s[15:8];
  endfunction

endpackage

// File: src/r2y420_cfg.sv
// configuration registers and derived chroma plane base offsets
// depends on r2y420_pkg
`timescale 1ns / 1ps

module r2y420_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [r2y420_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [r2y420_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output r2y420_pkg::cfg_t                   cfg_o
);
  import r2y420_pkg::*;

  logic [12:0] src_width_q;
  logic [12:0] src_height_q;
  logic [13:0] line_stride_q;
  logic [12:0] slice_height_q;
  logic        chroma_planar_q;

  logic [26:0]             base_full;
  logic [CHROMA_OFF_W-1:0] plane_size;
  logic [CHROMA_OFF_W-1:0] v_step;
  logic [CHROMA_OFF_W-1:0] base_u_q;
  logic [CHROMA_OFF_W-1:0] base_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_width_q     <= RST_SRC_WIDTH;
      src_height_q    <= RST_SRC_HEIGHT;
      line_stride_q   <= RST_LINE_STRIDE;
      slice_height_q  <= RST_SLICE_HEIGHT;
      chroma_planar_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_SRC_WIDTH:     src_width_q     <= cfg_data_i[12:0];
        REG_SRC_HEIGHT:    src_height_q    <= cfg_data_i[12:0];
        REG_LINE_STRIDE:   line_stride_q   <= cfg_data_i[13:0];
        REG_SLICE_HEIGHT:  slice_height_q  <= cfg_data_i[12:0];
        REG_CHROMA_PLANAR: chroma_planar_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // luma plane size, and the gap from u to v (one u plane or one byte)
  always_comb begin
    base_full  = 27'(line_stride_q) * 27'(slice_height_q);
    plane_size = CHROMA_OFF_W'(27'(line_stride_q >> 1) * 27'(slice_height_q >> 1));
    v_step     = chroma_planar_q ? plane_size : CHROMA_OFF_W'(1);
  end

  always_ff @(posedge clk_i) begin
    base_u_q <= base_full[CHROMA_OFF_W-1:0];
    base_v_q <= base_full[CHROMA_OFF_W-1:0] + v_step;
  end

  always_comb begin
    cfg_o.src_width     = src_width_q;
    cfg_o.src_height    = src_height_q;
    cfg_o.line_stride   = line_stride_q;
    cfg_o.slice_height  = slice_height_q;
    cfg_o.chroma_planar = chroma_planar_q;
    cfg_o.base_u        = base_u_q;
    cfg_o.base_v        = base_v_q;
  end

endmodule

// File: src/r2y420_front.sv
// input stage: raster counters, crop, 2x2 pair sums, upper row buffer, offset products
// depends on r2y420_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "rgba_to_yuv420_converter_unit_assert.svh"

module r2y420_front #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  r2y420_pkg::cfg_t                     cfg_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [7:0]                           red_i,
  input  logic [7:0]                           green_i,
  input  logic [7:0]                           blue_i,
  output logic                                 s1_valid_o,
  input  logic                                 s1_ready_i,
  output r2y420_pkg::rgb8_t                    s1_pix_o,
  output r2y420_pkg::rgb9_t                    s1_pair_o,
  output r2y420_pkg::rgb9_t                    s1_upper_o,
  output logic [r2y420_pkg::LUMA_OFF_W-1:0]    s1_luma_off_o,
  output logic [r2y420_pkg::CHROMA_OFF_W-1:0]  s1_chroma_off_o,
  output r2y420_pkg::flags_t                   s1_flags_o
);
  import r2y420_pkg::*;

  localparam int unsigned CW    = $clog2(MAX_WIDTH);
  localparam int unsigned RW    = $clog2(MAX_HEIGHT);
  localparam int unsigned AW    = (CW > 1) ? CW - 1 : 1;
  localparam int unsigned DEPTH = MAX_WIDTH / 2;
  localparam logic [DIM_W-1:0] MaxW = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] MaxH = DIM_W'(MAX_HEIGHT);

  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  rgb9_t         psum_q;

  logic [DIM_W-1:0] w, h, enc_w, enc_h;
  logic [DIM_W-1:0] col_ext, row_ext, col_inc, row_inc;
  logic             keep, accept, row_end, mem_we;
  logic [AW-1:0]    idx;
  rgb9_t            pair;
  rgb9_t            first_px;
  logic [13:0]      chroma_mult;
  logic [CHROMA_OFF_W-1:0] chroma_term;
  logic [LUMA_OFF_W-1:0]   luma_off;
  logic [CHROMA_OFF_W-1:0] chroma_off;
  flags_t           flags;

  rgb9_t upper_mem [DEPTH];
  rgb9_t upper_q;

  logic                    s1_v_q;
  rgb8_t                   s1_pix_q;
  rgb9_t                   s1_pair_q;
  logic [LUMA_OFF_W-1:0]   s1_luma_off_q;
  logic [CHROMA_OFF_W-1:0] s1_chroma_off_q;
  flags_t                  s1_flags_q;

  assign in_ready_o = !s1_v_q || s1_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    w       = ({1'b0, cfg_i.src_width} > MaxW) ? MaxW : {1'b0, cfg_i.src_width};
    h       = ({1'b0, cfg_i.src_height} > MaxH) ? MaxH : {1'b0, cfg_i.src_height};
    enc_w   = {w[DIM_W-1:1], 1'b0};
    enc_h   = {h[DIM_W-1:1], 1'b0};
    col_ext = DIM_W'(col_q);
    row_ext = DIM_W'(row_q);
    keep    = (col_ext < enc_w) && (row_ext < enc_h);
    col_inc = col_ext + DIM_W'(1);
    row_inc = row_ext + DIM_W'(1);
    row_end = col_inc >= w;
    idx     = AW'(col_q >> 1);
    mem_we  = accept && keep && col_q[0] && !row_q[0];
  end

  // counters move on every accepted item, kept or not
  always_comb begin
    col_d = col_inc[CW-1:0];
    row_d = row_q;
    if (row_end) begin
      col_d = '0;
      row_d = (row_inc >= h) ? '0 : row_inc[RW-1:0];
    end
  end

  always_comb begin
    pair.r     = psum_q.r + 9'(red_i);
    pair.g     = psum_q.g + 9'(green_i);
    pair.b     = psum_q.b + 9'(blue_i);
    first_px.r = 9'(red_i);
    first_px.g = 9'(green_i);
    first_px.b = 9'(blue_i);
  end

  // nv12 steps by the full stride and two bytes per block, i420 by half of each
  always_comb begin
    chroma_mult = cfg_i.chroma_planar ? {1'b0, cfg_i.line_stride[13:1]} : cfg_i.line_stride;
    chroma_term = cfg_i.chroma_planar ? CHROMA_OFF_W'(col_q >> 1)
                                      : CHROMA_OFF_W'({col_q[CW-1:1], 1'b0});
    luma_off    = LUMA_OFF_W'(row_q) * LUMA_OFF_W'(cfg_i.line_stride) + LUMA_OFF_W'(col_q);
    chroma_off  = CHROMA_OFF_W'(row_q >> 1) * CHROMA_OFF_W'(chroma_mult) + chroma_term;
    flags.chroma    = col_q[0] && row_q[0];
    flags.frame_end = (row_ext == enc_h - DIM_W'(1)) && (col_ext == enc_w - DIM_W'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      psum_q <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
      if (keep && !col_q[0]) begin
        psum_q <= first_px;
      end
    end
  end

  // upper row pair sums, written on even rows and read back on odd rows
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      upper_mem[idx] <= pair;
    end
    if (accept && keep) begin
      upper_q <= upper_mem[idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_v_q <= accept && keep;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && keep) begin
      s1_pix_q        <= '{b: blue_i, g: green_i, r: red_i};
      s1_pair_q       <= pair;
      s1_luma_off_q   <= luma_off;
      s1_chroma_off_q <= chroma_off;
      s1_flags_q      <= flags;
    end
  end

  assign s1_valid_o      = s1_v_q;
  assign s1_pix_o        = s1_pix_q;
  assign s1_pair_o       = s1_pair_q;
  assign s1_upper_o      = upper_q;
  assign s1_luma_off_o   = s1_luma_off_q;
  assign s1_chroma_off_o = s1_chroma_off_q;
  assign s1_flags_o      = s1_flags_q;

  `R2Y_ASSERT_NEXT(a_col_step, accept && !row_end, col_q == $past(col_q) + CW'(1), "column count did not step")
  `R2Y_ASSERT_NEXT(a_s1_hold, s1_v_q && !s1_ready_i, s1_v_q && $stable(s1_luma_off_q) && $stable(upper_q), "stalled input stage item changed")

endmodule

// File: src/r2y420_mid.sv
// middle stage: luma byte and 2x2 averaged rgb
// depends on r2y420_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "rgba_to_yuv420_converter_unit_assert.svh"

module r2y420_mid (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s1_valid_i,
  output logic                                 s1_ready_o,
  input  r2y420_pkg::rgb8_t                    s1_pix_i,
  input  r2y420_pkg::rgb9_t                    s1_pair_i,
  input  r2y420_pkg::rgb9_t                    s1_upper_i,
  input  logic [r2y420_pkg::LUMA_OFF_W-1:0]    s1_luma_off_i,
  input  logic [r2y420_pkg::CHROMA_OFF_W-1:0]  s1_chroma_off_i,
  input  r2y420_pkg::flags_t                   s1_flags_i,
  output logic                                 s2_valid_o,
  input  logic                                 s2_ready_i,
  output logic [7:0]                           s2_luma_o,
  output r2y420_pkg::rgb8_t                    s2_avg_o,
  output logic [r2y420_pkg::LUMA_OFF_W-1:0]    s2_luma_off_o,
  output logic [r2y420_pkg::CHROMA_OFF_W-1:0]  s2_chroma_off_o,
  output r2y420_pkg::flags_t                   s2_flags_o
);
  import r2y420_pkg::*;

  logic  [9:0] sum_r, sum_g, sum_b;
  rgb8_t avg;

  logic                    s2_v_q;
  logic [7:0]              s2_luma_q;
  rgb8_t                   s2_avg_q;
  logic [LUMA_OFF_W-1:0]   s2_luma_off_q;
  logic [CHROMA_OFF_W-1:0] s2_chroma_off_q;
  flags_t                  s2_flags_q;

  assign s1_ready_o = !s2_v_q || s2_ready_i;

  // truncated mean of the four pixels
  always_comb begin
    sum_r = 10'(s1_pair_i.r) + 10'(s1_upper_i.r);
    sum_g = 10'(s1_pair_i.g) + 10'(s1_upper_i.g);
    sum_b = 10'(s1_pair_i.b) + 10'(s1_upper_i.b);
    avg.r = sum_r[9:2];
    avg.g = sum_g[9:2];
    avg.b = sum_b[9:2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (s1_ready_o) begin
      s2_v_q <= s1_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_i && s1_ready_o) begin
      s2_luma_q       <= luma_of(s1_pix_i);
      s2_avg_q        <= avg;
      s2_luma_off_q   <= s1_luma_off_i;
      s2_chroma_off_q <= s1_chroma_off_i;
      s2_flags_q      <= s1_flags_i;
    end
  end

  assign s2_valid_o      = s2_v_q;
  assign s2_luma_o       = s2_luma_q;
  assign s2_avg_o        = s2_avg_q;
  assign s2_luma_off_o   = s2_luma_off_q;
  assign s2_chroma_off_o = s2_chroma_off_q;
  assign s2_flags_o      = s2_flags_q;

  `R2Y_ASSERT_NEXT(a_s2_capture, s1_valid_i && s1_ready_o, s2_v_q, "item lost entering middle stage")

endmodule

// File: src/r2y420_out.sv
// result register: chroma bytes and final u and v offsets
// depends on r2y420_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "rgba_to_yuv420_converter_unit_assert.svh"

module r2y420_out (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  r2y420_pkg::cfg_t                     cfg_i,
  input  logic                                 s2_valid_i,
  output logic                                 s2_ready_o,
  input  logic [7:0]                           s2_luma_i,
  input  r2y420_pkg::rgb8_t                    s2_avg_i,
  input  logic [r2y420_pkg::LUMA_OFF_W-1:0]    s2_luma_off_i,
  input  logic [r2y420_pkg::CHROMA_OFF_W-1:0]  s2_chroma_off_i,
  input  r2y420_pkg::flags_t                   s2_flags_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [r2y420_pkg::LUMA_OFF_W-1:0]    luma_offset_o,
  output logic [7:0]                           luma_byte_o,
  output logic                                 chroma_valid_o,
  output logic [r2y420_pkg::CHROMA_OFF_W-1:0]  u_offset_o,
  output logic [7:0]                           u_byte_o,
  output logic [r2y420_pkg::CHROMA_OFF_W-1:0]  v_offset_o,
  output logic [7:0]                           v_byte_o,
  output logic                                 frame_end_o
);
  import r2y420_pkg::*;

  logic [CHROMA_OFF_W-1:0] u_off, v_off;
  logic [7:0]              u_val, v_val;
  logic                    load;

  logic                    out_v_q;
  logic [LUMA_OFF_W-1:0]   luma_offset_q;
  logic [7:0]              luma_byte_q;
  logic                    chroma_valid_q;
  logic [CHROMA_OFF_W-1:0] u_offset_q;
  logic [7:0]              u_byte_q;
  logic [CHROMA_OFF_W-1:0] v_offset_q;
  logic [7:0]              v_byte_q;
  logic                    frame_end_q;

  assign s2_ready_o = !out_v_q || out_ready_i;
  assign load       = s2_valid_i && s2_ready_o;

  // u and v fields read zero on items that carry no chroma
  always_comb begin
    u_off = '0;
    v_off = '0;
    u_val = '0;
    v_val = '0;
    if (s2_flags_i.chroma) begin
      u_off = cfg_i.base_u + s2_chroma_off_i;
      v_off = cfg_i.base_v + s2_chroma_off_i;
      u_val = cb_of(s2_avg_i);
      v_val = cr_of(s2_avg_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (s2_ready_o) begin
      out_v_q <= s2_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      luma_offset_q  <= s2_luma_off_i;
      luma_byte_q    <= s2_luma_i;
      chroma_valid_q <= s2_flags_i.chroma;
      u_offset_q     <= u_off;
      u_byte_q       <= u_val;
      v_offset_q     <= v_off;
      v_byte_q       <= v_val;
      frame_end_q    <= s2_flags_i.frame_end;
    end
  end

  assign out_valid_o    = out_v_q;
  assign luma_offset_o  = luma_offset_q;
  assign luma_byte_o    = luma_byte_q;
  assign chroma_valid_o = chroma_valid_q;
  assign u_offset_o     = u_offset_q;
  assign u_byte_o       = u_byte_q;
  assign v_offset_o     = v_offset_q;
  assign v_byte_o       = v_byte_q;
  assign frame_end_o    = frame_end_q;

  `R2Y_ASSERT_IMPL(a_no_chroma_zero, out_v_q && !chroma_valid_q, u_offset_q == '0 && u_byte_q == '0 && v_offset_q == '0 && v_byte_q == '0, "chroma fields not cleared")
  `R2Y_ASSERT_NEXT(a_out_capture, load, out_v_q, "item lost entering result register")

endmodule

// File: src/rgba_to_yuv420_converter_unit.sv
// rgb to yuv 4:2:0 (nv12 / i420) converter, top level
// a kept pixel's result is registered in the input stage, middle stage and result register in turn
// throughput: one pixel per cycle while out_ready_i holds; three registered stages with per-stage ready
// cropped pixels are consumed and give no result
// reset: async active low, clears counters, pair sum, stage valids and registers
// to their defaults; the upper row buffer is not cleared, so no startup pass
`timescale 1ns / 1ps

module rgba_to_yuv420_converter_unit #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [r2y420_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [r2y420_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [7:0]                           red_i,
  input  logic [7:0]                           green_i,
  input  logic [7:0]                           blue_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [r2y420_pkg::LUMA_OFF_W-1:0]    luma_offset_o,
  output logic [7:0]                           luma_byte_o,
  output logic                                 chroma_valid_o,
  output logic [r2y420_pkg::CHROMA_OFF_W-1:0]  u_offset_o,
  output logic [7:0]                           u_byte_o,
  output logic [r2y420_pkg::CHROMA_OFF_W-1:0]  v_offset_o,
  output logic [7:0]                           v_byte_o,
  output logic                                 frame_end_o
);
  import r2y420_pkg::*;

  cfg_t cfg;

  logic                    s1_valid, s1_ready;
  rgb8_t                   s1_pix;
  rgb9_t                   s1_pair, s1_upper;
  logic [LUMA_OFF_W-1:0]   s1_luma_off;
  logic [CHROMA_OFF_W-1:0] s1_chroma_off;
  flags_t                  s1_flags;

  logic                    s2_valid, s2_ready;
  logic [7:0]              s2_luma;
  rgb8_t                   s2_avg;
  logic [LUMA_OFF_W-1:0]   s2_luma_off;
  logic [CHROMA_OFF_W-1:0] s2_chroma_off;
  flags_t                  s2_flags;

  r2y420_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  r2y420_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .red_i           (red_i),
    .green_i         (green_i),
    .blue_i          (blue_i),
    .s1_valid_o      (s1_valid),
    .s1_ready_i      (s1_ready),
    .s1_pix_o        (s1_pix),
    .s1_pair_o       (s1_pair),
    .s1_upper_o      (s1_upper),
    .s1_luma_off_o   (s1_luma_off),
    .s1_chroma_off_o (s1_chroma_off),
    .s1_flags_o      (s1_flags)
  );

  r2y420_mid u_mid (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s1_valid_i      (s1_valid),
    .s1_ready_o      (s1_ready),
    .s1_pix_i        (s1_pix),
    .s1_pair_i       (s1_pair),
    .s1_upper_i      (s1_upper),
    .s1_luma_off_i   (s1_luma_off),
    .s1_chroma_off_i (s1_chroma_off),
    .s1_flags_i      (s1_flags),
    .s2_valid_o      (s2_valid),
    .s2_ready_i      (s2_ready),
    .s2_luma_o       (s2_luma),
    .s2_avg_o        (s2_avg),
    .s2_luma_off_o   (s2_luma_off),
    .s2_chroma_off_o (s2_chroma_off),
    .s2_flags_o      (s2_flags)
  );

  r2y420_out u_out (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .s2_valid_i      (s2_valid),
    .s2_ready_o      (s2_ready),
    .s2_luma_i       (s2_luma),
    .s2_avg_i        (s2_avg),
    .s2_luma_off_i   (s2_luma_off),
    .s2_chroma_off_i (s2_chroma_off),
    .s2_flags_i      (s2_flags),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .luma_offset_o   (luma_offset_o),
    .luma_byte_o     (luma_byte_o),
    .chroma_valid_o  (chroma_valid_o),
    .u_offset_o      (u_offset_o),
    .u_byte_o        (u_byte_o),
    .v_offset_o      (v_offset_o),
    .v_byte_o        (v_byte_o),
    .frame_end_o     (frame_end_o)
  );

endmodule

// File: verif/yuv420_stream_checker.sv
// stream checker for the rgb to yuv 4:2:0 converter: tracks register writes,
// predicts each kept pixel's luma and chroma samples and compares the outputs
// depends on r2y420_pkg
`timescale 1ns / 1ps

module yuv420_stream_checker #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [r2y420_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [r2y420_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                                 in_valid_i,
  input  logic                                 in_ready_i,
  input  logic [7:0]                           red_i,
  input  logic [7:0]                           green_i,
  input  logic [7:0]                           blue_i,
  input  logic                                 out_valid_i,
  input  logic                                 out_ready_i,
  input  logic [r2y420_pkg::LUMA_OFF_W-1:0]    luma_offset_i,
  input  logic [7:0]                           luma_byte_i,
  input  logic                                 chroma_valid_i,
  input  logic [r2y420_pkg::CHROMA_OFF_W-1:0]  u_offset_i,
  input  logic [7:0]                           u_byte_i,
  input  logic [r2y420_pkg::CHROMA_OFF_W-1:0]  v_offset_i,
  input  logic [7:0]                           v_byte_i,
  input  logic                                 frame_end_i,
  output int                                   fail_count_o,
  output int                                   pending_o,
  output int                                   pixels_o,
  output int                                   samples_o,
  output int                                   chroma_samples_o
);

  import r2y420_pkg::*;

  typedef struct packed {
    logic [LUMA_OFF_W-1:0]   luma_offset;
    logic [7:0]              luma_byte;
    logic                    chroma_valid;
    logic [CHROMA_OFF_W-1:0] u_offset;
    logic [7:0]              u_byte;
    logic [CHROMA_OFF_W-1:0] v_offset;
    logic [7:0]              v_byte;
    logic                    frame_end;
  } yuv_sample_t;

  logic [12:0] src_width;
  logic [12:0] src_height;
  logic [13:0] line_stride;
  logic [12:0] slice_height;
  logic        chroma_planar;

  logic [11:0] col_cnt;
  logic [11:0] row_cnt;
  rgb9_t       pair_sum;
  rgb9_t       upper_sums [MAX_WIDTH/2];

  yuv_sample_t pending_samples [$];

  task automatic check_field(input string name, input logic [31:0] expected,
                             input logic [31:0] actual);
    if (expected !== actual) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, expected, actual);
      fail_count_o++;
    end
  endtask

  task automatic convert_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    int unsigned w, h, enc_w, enc_h, col, row, idx;
    int unsigned sr, sg, sb, ar, ag, ab;
    logic [63:0] base, half, u_off, v_off, luma_off;
    logic [31:0] y, cb, cr;
    rgb9_t       upper;
    yuv_sample_t s;
    w = (src_width > MAX_WIDTH) ? MAX_WIDTH : src_width;
    h = (src_height > MAX_HEIGHT) ? MAX_HEIGHT : src_height;
    enc_w = w & ~32'd1;
    enc_h = h & ~32'd1;
    col = col_cnt;
    row = row_cnt;
    if (col < enc_w && row < enc_h) begin
      s = '0;
      idx = (col >> 1) & (MAX_WIDTH/2 - 1);
      luma_off = 64'(row) * line_stride + col;
      s.luma_offset = luma_off[LUMA_OFF_W-1:0];
      y = ((66 * r + 129 * g + 25 * b + 128) >> 8) + 16;
      s.luma_byte = y[7:0];
      if ((col & 1) == 0) begin
        pair_sum.r = 9'(r);
        pair_sum.g = 9'(g);
        pair_sum.b = 9'(b);
      end else begin
        sr = pair_sum.r + r;
        sg = pair_sum.g + g;
        sb = pair_sum.b + b;
        if ((row & 1) == 0) begin
          upper.r = 9'(sr);
          upper.g = 9'(sg);
          upper.b = 9'(sb);
          upper_sums[idx] = upper;
        end else begin
          upper = upper_sums[idx];
          ar = (sr + upper.r) >> 2;
          ag = (sg + upper.g) >> 2;
          ab = (sb + upper.b) >> 2;
          base = 64'(line_stride) * slice_height;
          if (chroma_planar) begin
            half = 64'(line_stride >> 1);
            u_off = base + 64'(row >> 1) * half + (col >> 1);
            v_off = u_off + half * (slice_height >> 1);
          end else begin
            u_off = base + 64'(row >> 1) * line_stride + 2 * (col >> 1);
            v_off = u_off + 1;
          end
          // the bias keeps both sums positive so the shift is a floor
          cb = (112 * ab + 128 + 32768 - 38 * ar - 74 * ag) >> 8;
          cr = (112 * ar + 128 + 32768 - 94 * ag - 18 * ab) >> 8;
          s.chroma_valid = 1'b1;
          s.u_offset = u_off[CHROMA_OFF_W-1:0];
          s.u_byte = cb[7:0];
          s.v_offset = v_off[CHROMA_OFF_W-1:0];
          s.v_byte = cr[7:0];
          chroma_samples_o++;
        end
      end
      s.frame_end = (row == enc_h - 1) && (col == enc_w - 1);
      pending_samples.push_back(s);
      samples_o++;
    end
    // counters run over the source size, cropped pixels included
    col++;
    if (col >= w) begin
      col = 0;
      row++;
      if (row >= h) row = 0;
    end
    col_cnt = 12'(col);
    row_cnt = 12'(row);
    pixels_o++;
  endtask

  task automatic compare_sample();
    yuv_sample_t s;
    if (pending_samples.size() == 0) begin
      $error("unexpected output item at luma_offset 0x%0h", luma_offset_i);
      fail_count_o++;
    end else begin
      s = pending_samples.pop_front();
      check_field("luma_offset", 32'(s.luma_offset), 32'(luma_offset_i));
      check_field("luma_byte", 32'(s.luma_byte), 32'(luma_byte_i));
      check_field("chroma_valid", 32'(s.chroma_valid), 32'(chroma_valid_i));
      check_field("u_offset", 32'(s.u_offset), 32'(u_offset_i));
      check_field("u_byte", 32'(s.u_byte), 32'(u_byte_i));
      check_field("v_offset", 32'(s.v_offset), 32'(v_offset_i));
      check_field("v_byte", 32'(s.v_byte), 32'(v_byte_i));
      check_field("frame_end", 32'(s.frame_end), 32'(frame_end_i));
    end
  endtask

  initial begin
    fail_count_o = 0;
    pending_o = 0;
    pixels_o = 0;
    samples_o = 0;
    chroma_samples_o = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_width = RST_SRC_WIDTH;
      src_height = RST_SRC_HEIGHT;
      line_stride = RST_LINE_STRIDE;
      slice_height = RST_SLICE_HEIGHT;
      chroma_planar = 1'b0;
      col_cnt = '0;
      row_cnt = '0;
      pair_sum = '0;
      pending_samples.delete();
    end else begin
      if (out_valid_i && out_ready_i) compare_sample();
      if (in_valid_i && in_ready_i) convert_pixel(red_i, green_i, blue_i);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_SRC_WIDTH:     src_width = cfg_data_i[12:0];
          REG_SRC_HEIGHT:    src_height = cfg_data_i[12:0];
          REG_LINE_STRIDE:   line_stride = cfg_data_i[13:0];
          REG_SLICE_HEIGHT:  slice_height = cfg_data_i[12:0];
          REG_CHROMA_PLANAR: chroma_planar = cfg_data_i[0];
          default: ;
        endcase
      end
    end
    pending_o = pending_samples.size();
  end

endmodule

// File: verif/rgba_to_yuv420_converter_unit_tb.sv
// testbench top for rgba_to_yuv420_converter_unit: clock, reset, pixel and
// register stimulus, output stalls and the verdict
// depends on r2y420_pkg, yuv420_stream_checker and rgba_to_yuv420_converter_unit
`timescale 1ns / 1ps

module rgba_to_yuv420_converter_unit_tb;

  import r2y420_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 600000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam logic [CFG_IDX_W-1:0] UNUSED_REG_IDX = 3'd7;
  localparam logic [23:0] EXTREME_COLORS [8] = '{
    24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00,
    24'h0000FF, 24'hFF00FF, 24'h00FFFF, 24'hFFFF00
  };

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic [CFG_IDX_W-1:0]    cfg_idx_i;
  logic [CFG_DATA_W-1:0]   cfg_data_i;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic [7:0]              red_i;
  logic [7:0]              green_i;
  logic [7:0]              blue_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  logic [LUMA_OFF_W-1:0]   luma_offset_o;
  logic [7:0]              luma_byte_o;
  logic                    chroma_valid_o;
  logic [CHROMA_OFF_W-1:0] u_offset_o;
  logic [7:0]              u_byte_o;
  logic [CHROMA_OFF_W-1:0] v_offset_o;
  logic [7:0]              v_byte_o;
  logic                    frame_end_o;

  int          failures;
  int          pending_results;
  int          pixel_count;
  int          sample_count;
  int          chroma_count;
  int          settings_loaded;
  bit          calm;
  int unsigned cycle_count;

  always #6 clk_i = ~clk_i;

  rgba_to_yuv420_converter_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .red_i          (red_i),
    .green_i        (green_i),
    .blue_i         (blue_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .luma_offset_o  (luma_offset_o),
    .luma_byte_o    (luma_byte_o),
    .chroma_valid_o (chroma_valid_o),
    .u_offset_o     (u_offset_o),
    .u_byte_o       (u_byte_o),
    .v_offset_o     (v_offset_o),
    .v_byte_o       (v_byte_o),
    .frame_end_o    (frame_end_o)
  );

  yuv420_stream_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .red_i            (red_i),
    .green_i          (green_i),
    .blue_i           (blue_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .luma_offset_i    (luma_offset_o),
    .luma_byte_i      (luma_byte_o),
    .chroma_valid_i   (chroma_valid_o),
    .u_offset_i       (u_offset_o),
    .u_byte_i         (u_byte_o),
    .v_offset_i       (v_offset_o),
    .v_byte_i         (v_byte_o),
    .frame_end_i      (frame_end_o),
    .fail_count_o     (failures),
    .pending_o        (pending_results),
    .pixels_o         (pixel_count),
    .samples_o        (sample_count),
    .chroma_samples_o (chroma_count)
  );

  function automatic bit idles();
    return !calm && ($urandom_range(99) < 28);
  endfunction

  // all registers back to back, then a write to an unmapped index
  task automatic load_settings(input logic [13:0] width, input logic [13:0] height,
                               input logic [13:0] stride, input logic [13:0] slice,
                               input logic planar);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= REG_SRC_WIDTH;
    cfg_data_i <= width;
    @(negedge clk_i);
    cfg_idx_i <= REG_SRC_HEIGHT;
    cfg_data_i <= height;
    @(negedge clk_i);
    cfg_idx_i <= REG_LINE_STRIDE;
    cfg_data_i <= stride;
    @(negedge clk_i);
    cfg_idx_i <= REG_SLICE_HEIGHT;
    cfg_data_i <= slice;
    @(negedge clk_i);
    cfg_idx_i <= REG_CHROMA_PLANAR;
    cfg_data_i <= {13'($urandom), planar};
    @(negedge clk_i);
    cfg_idx_i <= UNUSED_REG_IDX;
    cfg_data_i <= 14'($urandom);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    settings_loaded++;
  endtask

  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    while (idles()) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    red_i <= r;
    green_i <= g;
    blue_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic send_random(input int unsigned count);
    repeat (count) send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // cropped pixels give no item, so wait for the pending items to drain, then SETTLE_CYCLES more
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_results != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d items still expected",
               cycle_count, pending_results);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ready_i <= !idles();
    end
  end

  initial begin
    logic [13:0] w, h, stride, slice;
    int unsigned mode;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    red_i = '0;
    green_i = '0;
    blue_i = '0;
    calm = 1'b0;
    cycle_count = 0;
    settings_loaded = 0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // one 4x2 nv12 frame of saturated colors
    load_settings(14'd4, 14'd2, 14'd4, 14'd2, 1'b0);
    for (int i = 0; i < 8; i++)
      send_pixel(EXTREME_COLORS[i][23:16], EXTREME_COLORS[i][15:8], EXTREME_COLORS[i][7:0]);
    settle();
    // odd 3x3 source in i420: last column and row are cropped, odd stride halves down
    load_settings(14'd3, 14'd3, 14'd3, 14'd3, 1'b1);
    for (int i = 0; i < 9; i++)
      send_pixel(EXTREME_COLORS[7-(i%8)][23:16], EXTREME_COLORS[i%8][15:8], 8'($urandom));
    settle();
    // zero width keeps nothing; four pixels bring the row count back to 0
    load_settings(14'd0, 14'd2, 14'd2, 14'd2, 1'b0);
    for (int i = 0; i < 4; i++)
      send_pixel(8'hFF, 8'hFF, 8'hFF);
    settle();
    // full 32x2 i420 frame, writes the upper row entries that later odd rows read
    load_settings(14'd32, 14'd2, 14'd40, 14'd4, 1'b1);
    send_random(64);
    settle();

    // oversized width, first row only
    load_settings(14'd8191, 14'd2, 14'd16383, 14'd8191, 1'b0);
    send_random(40);
    settle();
    // oversized height with a narrow frame, offsets wrap in i420
    load_settings(14'd2, 14'd8191, 14'd16383, 14'd8191, 1'b1);
    send_random(24);
    settle();
    // exact upper limits, partial rows only
    load_settings(14'd4096, 14'd4096, 14'd8192, 14'd4096, 1'b0);
    send_random(30);

    // random settings; phases start mid-frame so counters wrap at new sizes
    // widths stay at 32 or below so odd rows only read written pair sums
    for (int phase = 0; phase < 12; phase++) begin
      settle();
      calm = (phase == 6);
      mode = $urandom_range(5);
      case (mode)
        0: begin
          w = $urandom_range(1) ? 14'd0 : 14'($urandom_range(1, 8));
          h = (w == 0) ? 14'($urandom_range(0, 6)) : 14'd0;
          stride = 14'($urandom_range(2, 12));
          slice = 14'($urandom_range(2, 8));
        end
        1: begin
          w = 14'($urandom_range(32));
          h = 14'($urandom);
          stride = 14'($urandom);
          slice = 14'($urandom);
        end
        2: begin
          w = 14'($urandom_range(1, 10));
          h = 14'($urandom_range(1, 8));
          stride = 14'($urandom_range(3));
          slice = 14'($urandom_range(3));
        end
        default: begin
          w = 14'($urandom_range(1, 12));
          h = 14'($urandom_range(1, 8));
          stride = w + 14'($urandom_range(6));
          slice = h + 14'($urandom_range(4));
        end
      endcase
      load_settings(w, h, stride, slice, 1'($urandom));
      send_random($urandom_range(20, 34));
    end
    calm = 1'b0;
    settle();

    $display("%0d pixel items sent over %0d register settings", pixel_count, settings_loaded);
    $display("%0d output items compared, %0d of them with chroma", sample_count, chroma_count);
    if (failures == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
